### sv/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types and constants for the DCC command frame builder.
// ----------------------------------------------------------------------------
package dcc_pkg;

    localparam int FRAME_W = 51;

    localparam logic [22:0] PREAMBLE_LONG  = 23'h7F_FFFF;
    localparam logic [13:0] PREAMBLE_SHORT = 14'h3FFF;
    localparam logic [7:0]  EXPANSION_BYTE = 8'hDE;

    localparam logic [1:0]  SPEED_PREFIX   = 2'b01;
    localparam logic [2:0]  GRP_F0_PREFIX  = 3'b100;
    localparam logic [3:0]  GRP_F5_PREFIX  = 4'b1011;
    localparam logic [3:0]  GRP_F9_PREFIX  = 4'b1010;

    localparam logic [4:0]  MAX_STEP       = 5'd28;
    localparam logic [4:0]  STEP_OFFSET    = 5'd3;

    // Function number boundaries of the four groups
    localparam logic [4:0]  FN_F0          = 5'd0;
    localparam logic [4:0]  FN_F1          = 5'd1;
    localparam logic [4:0]  FN_F4          = 5'd4;
    localparam logic [4:0]  FN_F5          = 5'd5;
    localparam logic [4:0]  FN_F8          = 5'd8;
    localparam logic [4:0]  FN_F9          = 5'd9;
    localparam logic [4:0]  FN_F12         = 5'd12;
    localparam logic [4:0]  FN_F13         = 5'd13;
    localparam logic [4:0]  FN_F20         = 5'd20;

    typedef enum logic
    {
        CMD_SPEED = 1'b0,
        CMD_FUNC  = 1'b1
    } cmd_kind_t;

    // One accepted command word
    typedef struct packed
    {
        logic       func;
        logic [7:0] loco_address;
        logic       forward;
        logic [4:0] speed_step;
        logic [4:0] function_number;
        logic       function_on;
    } cmd_item_t;

    // Command byte handed from the state unit to the frame packer
    typedef struct packed
    {
        logic       three_byte;
        logic [7:0] cmd_byte;
    } cmd_byte_t;

endpackage

### sv/dcc_command_frame_builder.sv
// ----------------------------------------------------------------------------
// dcc_command_frame_builder
// Turns locomotive speed and function commands into 51-bit DCC frames.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  command | cmd_valid, cmd_stall | func, loco_address, forward, speed_step,
//          |                      | function_number, function_on
//  frame   | frm_valid, frm_stall | frame, three_byte
//
//  A command word lands in the input register, is encoded in one pass of
//  logic and lands in the result register, one word per cycle sustained
//  while frm_stall is low. For a function command the group registers
//  update on the same edge that moves the word into the result register.
//  Reset clears the group registers (all functions off) and both valid bits.
//  A stalled result holds; the input register keeps taking a word as long
//  as it is empty or its word can move on.
//
module dcc_command_frame_builder
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic                          func,
    input  logic [7:0]                    loco_address,
    input  logic                          forward,
    input  logic [4:0]                    speed_step,
    input  logic [4:0]                    function_number,
    input  logic                          function_on,

    output logic                          frm_valid,
    input  logic                          frm_stall,
    output logic [dcc_pkg::FRAME_W-1:0]   frame,
    output logic                          three_byte
);

    // Input register
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    dcc_pkg::cmd_item_t   s1_item_reg;

    // Result register
    logic                          frm_valid_reg;
    logic                          frm_valid_next;
    logic [dcc_pkg::FRAME_W-1:0]   frame_reg;
    logic                          three_byte_reg;

    logic                          accept;
    logic                          advance;
    dcc_pkg::cmd_byte_t            cmd;
    logic [dcc_pkg::FRAME_W-1:0]   frame_comb;

    // Advance the input word whenever the result slot is free or draining
    assign advance   = s1_valid_reg && (!frm_valid_reg || !frm_stall);
    assign cmd_stall = s1_valid_reg && frm_valid_reg && frm_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !advance);
    assign frm_valid_next = advance || (frm_valid_reg && frm_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            frm_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            frm_valid_reg <= frm_valid_next;
        end
    end

    // Payload registers: input captures on accept, result on advance; hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.func            <= func;
            s1_item_reg.loco_address    <= loco_address;
            s1_item_reg.forward         <= forward;
            s1_item_reg.speed_step      <= speed_step;
            s1_item_reg.function_number <= function_number;
            s1_item_reg.function_on     <= function_on;
        end
        if (advance)
        begin
            frame_reg      <= frame_comb;
            three_byte_reg <= cmd.three_byte;
        end
    end

    // Function state and command byte encoding
    dcc_func_state u_state
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cmd     (cmd)
    );

    // Frame assembly with error byte
    dcc_frame_pack u_pack
    (
        .loco_address (s1_item_reg.loco_address),
        .cmd          (cmd),
        .frame        (frame_comb)
    );

    assign frm_valid  = frm_valid_reg;
    assign frame      = frame_reg;
    assign three_byte = three_byte_reg;

    // Input stalls only while a word waits behind a stalled result
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (s1_valid_reg && frm_valid_reg))
        else $error("input stalled with no word held");

    // Every delivered frame closes with the packet end bit
    a_end_bit: assert property (@(posedge clk) disable iff (!rst_n)
        frm_valid |-> frame[0] == 1'b1)
        else $error("frame without end bit");

    // Two-byte frames carry a correct error byte
    a_err_two: assert property (@(posedge clk) disable iff (!rst_n)
        (frm_valid && !three_byte) |-> frame[8:1] == (frame[26:19] ^ frame[17:10]))
        else $error("two-byte error byte mismatch");

    // Three-byte frames end the short preamble and carry the expansion byte
    a_three_layout: assert property (@(posedge clk) disable iff (!rst_n)
        (frm_valid && three_byte) |->
            (frame[37:36] == 2'b10 && frame[26:19] == dcc_pkg::EXPANSION_BYTE))
        else $error("three-byte layout broken");

    // A word that moves on shows up as a result on the next edge
    a_advance_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> frm_valid)
        else $error("advanced word lost");

endmodule

### sv/dcc_func_state.sv
// ----------------------------------------------------------------------------
// dcc_func_state
// Function group registers and command byte encoding for one command word.
// ----------------------------------------------------------------------------
module dcc_func_state
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  dcc_pkg::cmd_item_t    item,
    output dcc_pkg::cmd_byte_t    cmd
);

    logic [4:0] grp_f0_reg;
    logic [3:0] grp_f5_reg;
    logic [3:0] grp_f9_reg;
    logic [7:0] grp_f13_reg;

    logic [4:0] grp_f0_next;
    logic [3:0] grp_f5_next;
    logic [3:0] grp_f9_next;
    logic [7:0] grp_f13_next;

    logic [4:0] step_sat;
    logic [4:0] step_code;
    logic [4:0] num;

    assign num = item.function_number;

    // Apply the on/off to the addressed bit; numbers above F20 touch nothing
    always_comb
    begin
        grp_f0_next  = grp_f0_reg;
        grp_f5_next  = grp_f5_reg;
        grp_f9_next  = grp_f9_reg;
        grp_f13_next = grp_f13_reg;
        if (num == dcc_pkg::FN_F0)
        begin
            grp_f0_next[4] = item.function_on;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (num == dcc_pkg::FN_F1 + 5'(i))
            begin
                grp_f0_next[i] = item.function_on;
            end
            if (num == dcc_pkg::FN_F5 + 5'(i))
            begin
                grp_f5_next[i] = item.function_on;
            end
            if (num == dcc_pkg::FN_F9 + 5'(i))
            begin
                grp_f9_next[i] = item.function_on;
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            if (num == dcc_pkg::FN_F13 + 5'(i))
            begin
                grp_f13_next[i] = item.function_on;
            end
        end
    end

    // 28-step code: C S3..S0 with S3..S0 C = step + 3, stop encodes as zero
    always_comb
    begin
        logic [4:0] v;
        step_sat  = (item.speed_step > dcc_pkg::MAX_STEP) ? dcc_pkg::MAX_STEP
                                                          : item.speed_step;
        v         = step_sat + dcc_pkg::STEP_OFFSET;
        step_code = (step_sat == 5'd0) ? 5'd0 : {v[0], v[4:1]};
    end

    always_comb
    begin
        cmd.three_byte = 1'b0;
        priority if (item.func == dcc_pkg::CMD_SPEED)
        begin
            cmd.cmd_byte = {dcc_pkg::SPEED_PREFIX, item.forward, step_code};
        end
        else if (num <= dcc_pkg::FN_F4)
        begin
            cmd.cmd_byte = {dcc_pkg::GRP_F0_PREFIX, grp_f0_next};
        end
        else if (num <= dcc_pkg::FN_F8)
        begin
            cmd.cmd_byte = {dcc_pkg::GRP_F5_PREFIX, grp_f5_next};
        end
        else if (num <= dcc_pkg::FN_F12)
        begin
            cmd.cmd_byte = {dcc_pkg::GRP_F9_PREFIX, grp_f9_next};
        end
        else
        begin
            cmd.cmd_byte   = grp_f13_next;
            cmd.three_byte = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_f0_reg  <= '0;
            grp_f5_reg  <= '0;
            grp_f9_reg  <= '0;
            grp_f13_reg <= '0;
        end
        else if (advance && item.func == dcc_pkg::CMD_FUNC)
        begin
            grp_f0_reg  <= grp_f0_next;
            grp_f5_reg  <= grp_f5_next;
            grp_f9_reg  <= grp_f9_next;
            grp_f13_reg <= grp_f13_next;
        end
    end

endmodule

### sv/dcc_frame_pack.sv
// ----------------------------------------------------------------------------
// dcc_frame_pack
// Builds the serial frame: preamble, start bits, bytes, error byte, end bit.
// ----------------------------------------------------------------------------
module dcc_frame_pack
(
    input  logic [7:0]                   loco_address,
    input  dcc_pkg::cmd_byte_t           cmd,
    output logic [dcc_pkg::FRAME_W-1:0]  frame
);

    logic [7:0] err_byte;

    always_comb
    begin
        if (cmd.three_byte)
        begin
            err_byte = loco_address ^ dcc_pkg::EXPANSION_BYTE ^ cmd.cmd_byte;
            frame    = {dcc_pkg::PREAMBLE_SHORT, 1'b0, loco_address,
                        1'b0, dcc_pkg::EXPANSION_BYTE, 1'b0, cmd.cmd_byte,
                        1'b0, err_byte, 1'b1};
        end
        else
        begin
            err_byte = loco_address ^ cmd.cmd_byte;
            frame    = {dcc_pkg::PREAMBLE_LONG, 1'b0, loco_address,
                        1'b0, cmd.cmd_byte, 1'b0, err_byte, 1'b1};
        end
    end

endmodule
